@@ src/square_matrix_rotator_macros.svh @@
// Assertion macros used by the checker file.
`ifndef SQUARE_MATRIX_ROTATOR_MACROS_SVH
`define SQUARE_MATRIX_ROTATOR_MACROS_SVH

// Antecedent true in one cycle implies consequent in the next cycle.
`define SQROT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqrot check failed: next-cycle property");

// Antecedent true implies consequent in the same cycle.
`define SQROT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqrot check failed: same-cycle property");

`endif

@@ src/sqrot_pkg.sv @@
`timescale 1ns / 1ps

package sqrot_pkg;

   localparam int DataW = 32;
   localparam int SideW = 4;
   localparam int TurnW = 2;
   localparam int TotalW = 8;

   // Register indexes, selected by paddr[2]
   localparam logic RegSide  = 1'b0;
   localparam logic RegTurns = 1'b1;

   localparam logic [SideW-1:0] SideReset  = 4'd8;
   localparam logic [TurnW-1:0] TurnsReset = 2'd0;

   // Quarter-turn codes
   localparam logic [TurnW-1:0] TurnZero  = 2'd0;
   localparam logic [TurnW-1:0] TurnOne   = 2'd1;
   localparam logic [TurnW-1:0] TurnTwo   = 2'd2;
   localparam logic [TurnW-1:0] TurnThree = 2'd3;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic start_emit;
      logic rd_issue;
   } cmd_type;

   typedef struct packed {
      logic frame_full;
      logic last_read;
      logic slot_free;
   } status_type;

endpackage

@@ src/sqrot_ctrl.sv @@
`timescale 1ns / 1ps

module sqrot_ctrl import sqrot_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Take items only while loading
   assign req_stall = (state_ff != ST_LOAD);

   always_comb begin
      cmd.load_wr    = (state_ff == ST_LOAD) && req_valid;
      cmd.start_emit = cmd.load_wr && status.frame_full;
      cmd.rd_issue   = (state_ff == ST_EMIT) && status.slot_free;
   end

   // Advance between load and emit phases
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (cmd.start_emit) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.rd_issue && status.last_read) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

endmodule

@@ src/sqrot_dp.sv @@
`timescale 1ns / 1ps

module sqrot_dp import sqrot_pkg::*; #(
   parameter int MAX_SIZE = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [SideW-1:0]        cfg_side,
   input  logic [TurnW-1:0]        cfg_turns,
   input  logic                    side_wr,
   input  logic signed [DataW-1:0] req_element_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DataW-1:0] rsp_element_out,
   output logic                    rsp_last_element
);

   localparam int Cells = MAX_SIZE * MAX_SIZE;
   localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int CmpW  = ((AddrW > TotalW) ? AddrW : TotalW) + 1;
   localparam logic [SideW-1:0] MaxSide = (MAX_SIZE > 15) ? 4'd15 : SideW'(MAX_SIZE);

   logic [DataW-1:0]  store_mem [Cells];

   logic [AddrW-1:0]  load_count_ff, load_count_in;
   logic [SideW-1:0]  row_ff, row_in, col_ff, col_in;
   logic [TurnW-1:0]  turns_ff;
   logic [DataW-1:0]  rd_data_ff;
   logic              pend_ff, pend_in;
   logic              pend_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] rsp_elem_ff;
   logic              rsp_last_ff;

   logic [SideW-1:0]  side_n, side_m1;
   logic [TotalW-1:0] total;
   logic [SideW-1:0]  src_row, src_col;
   logic [TotalW-1:0] src_index;
   logic [AddrW-1:0]  rd_addr;
   logic              move;

   // Clamp the configured side into 1..MaxSide
   always_comb begin
      side_n = cfg_side;
      if (side_n == '0) side_n = 4'd1;
      if (side_n > MaxSide) side_n = MaxSide;
   end
   assign side_m1 = side_n - 4'd1;
   assign total   = TotalW'(side_n) * TotalW'(side_n);

   assign status.frame_full = (CmpW'(load_count_ff) + CmpW'(1)) >= CmpW'(total);
   assign status.last_read  = (row_ff == side_m1) && (col_ff == side_m1);

   // Load counter: wrap at frame end, drop partial frame on side write
   always_comb begin
      load_count_in = load_count_ff;
      if (side_wr) load_count_in = '0;
      else if (cmd.load_wr) begin
         if (status.frame_full) load_count_in = '0;
         else                   load_count_in = load_count_ff + AddrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) load_count_ff <= '0;
      else       load_count_ff <= load_count_in;
   end

   // Emission scan over output row and column
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.start_emit) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.rd_issue) begin
         if (col_ff == side_m1) begin
            col_in = '0;
            row_in = row_ff + 4'd1;
         end else begin
            col_in = col_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      if (cmd.start_emit) turns_ff <= cfg_turns;
   end

   // Map output position to source position
   always_comb begin
      case (turns_ff)
         TurnOne: begin
            src_row = side_m1 - col_ff;
            src_col = row_ff;
         end
         TurnTwo: begin
            src_row = side_m1 - row_ff;
            src_col = side_m1 - col_ff;
         end
         TurnThree: begin
            src_row = col_ff;
            src_col = side_m1 - row_ff;
         end
         default: begin
            src_row = row_ff;
            src_col = col_ff;
         end
      endcase
   end

   assign src_index = TotalW'(src_row) * TotalW'(side_n) + TotalW'(src_col);
   assign rd_addr   = AddrW'(src_index);

   // Matrix store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_wr) store_mem[load_count_ff] <= req_element_in;
      if (cmd.rd_issue) begin
         rd_data_ff   <= store_mem[rd_addr];
         pend_last_ff <= status.last_read;
      end
   end

   // Read stage to output register hand-off
   assign move             = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign status.slot_free = !pend_ff || move;

   always_comb begin
      pend_in = pend_ff;
      if (cmd.rd_issue) pend_in = 1'b1;
      else if (move)    pend_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move)            rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the output item while stalled
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_elem_ff <= $signed(rd_data_ff);
         rsp_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_out  = rsp_elem_ff;
   assign rsp_last_element = rsp_last_ff;

endmodule

@@ src/square_matrix_rotator.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Ports
// req      | in        | req_valid, req_stall, req_element_in
// rsp      | out       | rsp_valid, rsp_stall, rsp_element_out, rsp_last_element
// csr      | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A frame of N*N items loads at one item per cycle into the matrix store.
// Emission then reads the store's single read port once per cycle while the output
// is not stalled: N*N results follow through the read data and output registers.
// Input is stalled during emission. Reset is synchronous; no clearing pass, the
// store is only read after being written in the same frame. Output stalls pause
// emission without loss.

module square_matrix_rotator import sqrot_pkg::*; #(
   parameter int MAX_SIZE = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [DataW-1:0] req_element_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DataW-1:0] rsp_element_out,
   output logic                    rsp_last_element,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [SideW-1:0] side_ff;
   logic [TurnW-1:0] turns_ff;
   logic             csr_wr;
   logic             side_wr;
   logic             turns_wr;
   cmd_type          cmd;
   status_type       status;

   // Configuration registers
   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite;
   assign side_wr  = csr_wr && (paddr[2] == RegSide);
   assign turns_wr = csr_wr && (paddr[2] == RegTurns);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= SideReset;
         turns_ff <= TurnsReset;
      end else begin
         if (side_wr)  side_ff  <= pwdata[SideW-1:0];
         if (turns_wr) turns_ff <= pwdata[TurnW-1:0];
      end
   end

   // Register read-back
   always_comb begin
      if (paddr[2] == RegSide) prdata = {28'd0, side_ff};
      else                     prdata = {30'd0, turns_ff};
   end

   sqrot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sqrot_dp #(
      .MAX_SIZE (MAX_SIZE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg_side         (side_ff),
      .cfg_turns        (turns_ff),
      .side_wr          (side_wr),
      .req_element_in   (req_element_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element_out  (rsp_element_out),
      .rsp_last_element (rsp_last_element)
   );

endmodule

@@ src/sqrot_checker.sv @@
`timescale 1ns / 1ps
`include "square_matrix_rotator_macros.svh"

module sqrot_checker import sqrot_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [DataW-1:0] rsp_element_out,
   input logic                    rsp_last_element,
   input logic                    pready
);

   // Stalled result item holds
   `SQROT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_element_out) && $stable(rsp_last_element))

   // Reset empties the output
   `SQROT_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // A frame streams without gaps until its last item
   `SQROT_ASSERT_NEXT(a_rsp_gapless, clock, reset, rsp_valid && !rsp_stall && !rsp_last_element,
      rsp_valid)

   // Register port never waits
   `SQROT_ASSERT_SAME(a_pready_high, clock, reset, 1'b1, pready)

endmodule

bind square_matrix_rotator sqrot_checker u_sqrot_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import sqrot_pkg::*; ();

   localparam int MaxSide = 8;
   localparam int Cells = MaxSide * MaxSide;
   localparam int IdxW = $clog2(Cells);
   localparam int SettleCycles = 8;
   localparam int CycleLimit = 400000;
   localparam int RandomTarget = 190;

   typedef struct {
      logic signed [DataW-1:0] element;
      logic last;
   } rotated_element_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DataW-1:0] req_element_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DataW-1:0] rsp_element_out;
   logic rsp_last_element;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // Predictor state: loaded elements, fill count and register copies
   logic [DataW-1:0] matrix_image [Cells];
   int unsigned frame_fill;
   logic [SideW-1:0] side_code;
   logic [TurnW-1:0] turn_code;
   rotated_element_type pending_elements [$];

   int mismatches = 0;
   int items_sent = 0;
   int unsigned cycle_count = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   square_matrix_rotator #(.MAX_SIZE(MaxSide)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_element_in(req_element_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_element_out(rsp_element_out),
      .rsp_last_element(rsp_last_element),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rotated_element_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elements.size() == 0) begin
            $error("unexpected result: element_out %h last_element %b",
                   rsp_element_out, rsp_last_element);
            mismatches++;
         end else begin
            want = pending_elements.pop_front();
            if (rsp_element_out !== want.element) begin
               $error("element_out: expected %h, got %h", want.element, rsp_element_out);
               mismatches++;
            end
            if (rsp_last_element !== want.last) begin
               $error("last_element: expected %b, got %b", want.last, rsp_last_element);
               mismatches++;
            end
         end
      end
   end

   function automatic int unsigned side_in_effect(input logic [SideW-1:0] code);
      int unsigned n;
      n = 32'(code);
      if (n == 0) n = 1;
      if (n > MaxSide) n = MaxSide;
      return n;
   endfunction

   // Store one element; on the completing one, queue the rotated frame
   task automatic load_element(input logic [DataW-1:0] value);
      int unsigned n;
      int unsigned total;
      int unsigned sr;
      int unsigned sc;
      rotated_element_type item;
      n = side_in_effect(side_code);
      total = n * n;
      if (frame_fill >= total) frame_fill = 0;
      matrix_image[IdxW'(frame_fill % Cells)] = value;
      frame_fill++;
      if (frame_fill >= total) begin
         frame_fill = 0;
         for (int unsigned r = 0; r < n; r++) begin
            for (int unsigned c = 0; c < n; c++) begin
               case (turn_code)
                  TurnOne: begin
                     sr = n - 1 - c;
                     sc = r;
                  end
                  TurnTwo: begin
                     sr = n - 1 - r;
                     sc = n - 1 - c;
                  end
                  TurnThree: begin
                     sr = c;
                     sc = n - 1 - r;
                  end
                  default: begin
                     sr = r;
                     sc = c;
                  end
               endcase
               item.element = matrix_image[IdxW'((sr * n + sc) % Cells)];
               item.last = (r * n + c + 1 == total);
               pending_elements.push_back(item);
            end
         end
      end
   endtask

   // Offer one item and hold it until accepted, then maybe idle
   task automatic send_element(input logic [DataW-1:0] value);
      req_valid <= 1'b1;
      req_element_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_element(value);
      items_sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Setup and access cycles of one register write
   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_sel == RegSide) begin
         side_code = value[SideW-1:0];
         frame_fill = 0;
      end else begin
         turn_code = value[TurnW-1:0];
      end
   endtask

   // Setup and access cycles of one register read, checked against the copy
   task automatic csr_read_check(input logic reg_sel);
      logic [31:0] want;
      if (reg_sel == RegSide) want = {28'd0, side_code};
      else                    want = {30'd0, turn_code};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         $error("prdata: expected %h, got %h", want, prdata);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [DataW-1:0] pick_element();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_frame(input int unsigned count);
      repeat (count) send_element(pick_element());
   endtask

   // Reset values of side and turns: a full frame passed through
   task automatic test_reset_frame();
      send_frame(side_in_effect(side_code) ** 2);
      wait_idle();
   endtask

   // Every turn on a 2x2 of extreme values
   task automatic test_turns_directed();
      logic [DataW-1:0] corners [4];
      corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      csr_write(RegSide, 32'd2);
      for (int t = 0; t < 4; t++) begin
         csr_write(RegTurns, t);
         foreach (corners[i]) send_element(corners[i]);
         wait_idle();
      end
   endtask

   // Side of zero acts as one, side of one is a single element
   task automatic test_side_bounds();
      csr_write(RegSide, 32'd0);
      send_element(32'h5A5A_A5A5);
      wait_idle();
      csr_write(RegSide, 32'd1);
      csr_write(RegTurns, 32'(TurnThree));
      send_element(32'hA5A5_5A5A);
      wait_idle();
   endtask

   // Both registers read back what was written
   task automatic test_register_readback();
      csr_read_check(RegSide);
      csr_read_check(RegTurns);
   endtask

   // Side write drops a partial frame; turns are taken at emission
   task automatic test_mid_frame_writes();
      csr_write(RegSide, 32'd2);
      csr_write(RegTurns, 32'(TurnZero));
      send_frame(3);
      wait_idle();
      csr_write(RegSide, 32'd2);
      send_frame(4);
      wait_idle();
      send_frame(2);
      wait_idle();
      csr_write(RegTurns, 32'(TurnThree));
      send_frame(2);
      wait_idle();
   endtask

   // Random settings and frames, mostly small, some cut short
   task automatic test_random_frames();
      int unsigned n;
      int unsigned pick;
      logic [31:0] junk;
      while (items_sent < RandomTarget) begin
         junk = $urandom;
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) n = $urandom_range(1, 4);
            else if (pick < 16) n = 0;
            else if (pick < 18) n = $urandom_range(5, 8);
            else n = $urandom_range(9, 15);
            csr_write(RegSide, {junk[31:SideW], n[SideW-1:0]});
         end
         if ($urandom_range(0, 1) == 0)
            csr_write(RegTurns, {junk[31:TurnW], 2'($urandom_range(0, 3))});
         n = side_in_effect(side_code) ** 2;
         if (n > 1 && $urandom_range(0, 7) == 0) begin
            send_frame($urandom_range(1, n - 1));
            wait_idle();
            csr_write(RegSide, {28'd0, side_code});
            n = side_in_effect(side_code) ** 2;
         end
         send_frame(n);
         wait_idle();
      end
   endtask

   // Closing frames back to back with both sides running freely
   task automatic test_calm_tail();
      calm = 1'b1;
      csr_write(RegSide, 32'd3);
      csr_write(RegTurns, $urandom_range(0, 3));
      for (int t = 0; t < 2; t++) begin
         send_frame(9);
      end
      wait_idle();
   endtask

   initial begin
      side_code = SideReset;
      turn_code = TurnsReset;
      frame_fill = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_frame();
      test_turns_directed();
      test_side_bounds();
      test_register_readback();
      test_mid_frame_writes();
      test_random_frames();
      test_calm_tail();
      if (pending_elements.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
